// ===== rtl/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the matrix-vector affine core.
// ----------------------------------------------------------------------------
package mva_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 16;
    localparam int DATA_WIDTH = 16;
    localparam int FRAC_BITS  = 12;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CNT_W      = 5;
    localparam int SUM_W      = 32;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int ACC_W      = PROD_W + COL_W + 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        OP_MAT  = 2'd0,
        OP_VEC  = 2'd1,
        OP_BIAS = 2'd2,
        OP_CALC = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS = 2'd0,
        CFG_COLS = 2'd1,
        CFG_BIAS = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_op                           op;
        logic [ROW_W-1:0]              row;
        logic [COL_W-1:0]              col;
        logic signed [DATA_WIDTH-1:0]  value;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] last_row;
        logic [COL_W-1:0] last_col;
        logic             use_bias;
    } t_cfg;

    function automatic logic [ROW_W-1:0] last_row_of(input logic [CNT_W-1:0] v);
        logic [ROW_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_ROWS) begin
            res = ROW_W'(MAX_ROWS - 1);
        end else begin
            res = ROW_W'(v - CNT_W'(1));
        end
        return res;
    endfunction

    function automatic logic [COL_W-1:0] last_col_of(input logic [CNT_W-1:0] v);
        logic [COL_W-1:0] res;
        if (v == '0) begin
            res = '0;
        end else if (int'(v) > MAX_COLS) begin
            res = COL_W'(MAX_COLS - 1);
        end else begin
            res = COL_W'(v - CNT_W'(1));
        end
        return res;
    endfunction

endpackage

// ===== rtl/mva_front.sv =====
// ----------------------------------------------------------------------------
// mva_front
// Configuration registers, item decode and the word queue to the back end.
// ----------------------------------------------------------------------------
module mva_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mva_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [mva_pkg::ROW_W-1:0]         i_row,
    input  logic [mva_pkg::COL_W-1:0]         i_col,
    input  logic signed [mva_pkg::DATA_WIDTH-1:0] i_value,
    output logic                              o_item_valid,
    output mva_pkg::t_item                    o_item,
    input  logic                              i_item_pop,
    output mva_pkg::t_cfg                     o_cfg
);
    import mva_pkg::*;

    logic [CNT_W-1:0]   r_rows;
    logic [CNT_W-1:0]   r_cols;
    logic               r_use_bias;
    t_item              r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QPTR_W:0]    r_count;
    logic               full;
    logic               push;
    logic               pop;
    t_item              item_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= CNT_W'(16);
            r_cols     <= CNT_W'(16);
            r_use_bias <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows     <= i_cfg_data;
                CFG_COLS: r_cols     <= i_cfg_data;
                CFG_BIAS: r_use_bias <= i_cfg_data[0];
                default:  ;
            endcase
        end
    end

    assign o_cfg.last_row = last_row_of(r_rows);
    assign o_cfg.last_col = last_col_of(r_cols);
    assign o_cfg.use_bias = r_use_bias;

    always_comb begin
        item_in.op    = t_op'(i_func);
        item_in.row   = i_row;
        item_in.col   = i_col;
        item_in.value = i_value;
    end

    assign full         = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_in_stall   = full;
    assign push         = i_in_valid && !full;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_queue[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wr_ptr] <= item_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + (QPTR_W+1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/mva_back.sv =====
// ----------------------------------------------------------------------------
// mva_back
// Element stores, row/column sequencer and multiply-accumulate pipeline.
// ----------------------------------------------------------------------------
module mva_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_item_valid,
    input  mva_pkg::t_item                i_item,
    output logic                          o_item_pop,
    input  mva_pkg::t_cfg                 i_cfg,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [mva_pkg::ROW_W-1:0]     o_row_index,
    output logic signed [mva_pkg::SUM_W-1:0] o_sum_value,
    output logic                          o_last
);
    import mva_pkg::*;

    logic signed [DATA_WIDTH-1:0] r_mat_mem  [MAX_ROWS*MAX_COLS];
    logic signed [DATA_WIDTH-1:0] r_vec_mem  [MAX_COLS];
    logic signed [DATA_WIDTH-1:0] r_bias_mem [MAX_ROWS];

    t_seq_state          r_state, n_state;
    logic [ROW_W-1:0]    r_r, n_r;
    logic [COL_W-1:0]    r_c, n_c;

    logic                r_s1_valid;
    logic [ROW_W-1:0]    r_s1_row;
    logic                r_s1_first, r_s1_lastc, r_s1_lastr;
    logic signed [DATA_WIDTH-1:0] r_s1_mat, r_s1_vec, r_s1_bias;

    logic                r_s2_valid;
    logic [ROW_W-1:0]    r_s2_row;
    logic                r_s2_first, r_s2_lastc, r_s2_lastr;
    logic signed [PROD_W-1:0]     r_s2_prod;
    logic signed [DATA_WIDTH-1:0] r_s2_bias;

    logic signed [ACC_W-1:0] r_acc;
    logic                r_out_valid;
    logic [ROW_W-1:0]    r_out_row;
    logic signed [SUM_W-1:0] r_out_sum;
    logic                r_out_last;

    logic                adv;
    logic                issue;
    logic                pop;
    logic signed [ACC_W-1:0] bias_term;
    logic signed [ACC_W-1:0] acc_base;
    logic signed [ACC_W-1:0] acc_sum;
    logic signed [ACC_W-1:0] acc_shift;

    assign adv        = !r_out_valid || !i_out_stall;
    assign issue      = (r_state == SEQ_RUN) && adv;
    assign pop        = i_item_valid && (r_state == SEQ_IDLE);
    assign o_item_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_r     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_r     <= n_r;
            r_c     <= n_c;
        end
    end

    always_comb begin
        n_state = r_state;
        n_r     = r_r;
        n_c     = r_c;
        unique case (r_state)
            SEQ_IDLE: begin
                if (pop && i_item.op == OP_CALC) begin
                    n_state = SEQ_RUN;
                    n_r     = '0;
                    n_c     = '0;
                end
            end
            SEQ_RUN: begin
                if (adv) begin
                    if (r_c == i_cfg.last_col) begin
                        n_c = '0;
                        if (r_r == i_cfg.last_row) begin
                            n_state = SEQ_IDLE;
                        end else begin
                            n_r = r_r + ROW_W'(1);
                        end
                    end else begin
                        n_c = r_c + COL_W'(1);
                    end
                end
            end
            default: n_state = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            unique case (i_item.op)
                OP_MAT:  r_mat_mem[{i_item.row, i_item.col}] <= i_item.value;
                OP_VEC:  r_vec_mem[i_item.col]               <= i_item.value;
                OP_BIAS: r_bias_mem[i_item.row]              <= i_item.value;
                default: ;
            endcase
        end
        if (issue) begin
            r_s1_mat  <= r_mat_mem[{r_r, r_c}];
            r_s1_vec  <= r_vec_mem[r_c];
            r_s1_bias <= r_bias_mem[r_r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_row   <= r_r;
            r_s1_first <= (r_c == '0);
            r_s1_lastc <= (r_c == i_cfg.last_col);
            r_s1_lastr <= (r_r == i_cfg.last_row);
            r_s2_row   <= r_s1_row;
            r_s2_first <= r_s1_first;
            r_s2_lastc <= r_s1_lastc;
            r_s2_lastr <= r_s1_lastr;
            r_s2_prod  <= r_s1_mat * r_s1_vec;
            r_s2_bias  <= r_s1_bias;
        end
    end

    always_comb begin
        bias_term = i_cfg.use_bias ? (ACC_W'(r_s2_bias) <<< FRAC_BITS) : '0;
        acc_base  = r_s2_first ? bias_term : r_acc;
        acc_sum   = acc_base + ACC_W'(r_s2_prod);
        acc_shift = acc_sum >>> FRAC_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s2_valid) begin
            r_acc <= acc_sum;
        end
        if (adv && r_s2_valid && r_s2_lastc) begin
            r_out_row  <= r_s2_row;
            r_out_sum  <= SUM_W'(acc_shift);
            r_out_last <= r_s2_lastr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= (r_state == SEQ_RUN);
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid && r_s2_lastc;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_index = r_out_row;
    assign o_sum_value = r_out_sum;
    assign o_last      = r_out_last;

endmodule

// ===== rtl/matrix_vector_affine_core.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_affine_core
// Dense y = M*a + b over a 16x16 Q4.12 matrix with wrapping Q20.12 results.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall): each word loads one matrix element,
// one input vector element or one bias element, or starts a compute (func 3).
// A four-word queue sits in front of the execution side, so load words are
// taken one per cycle until the queue fills behind a running compute.
// A load word is written to its store as it leaves the queue. A compute
// word runs rows_in_use * cols_in_use multiply-accumulates on a single
// multiplier fed by one read port per store; each element is registered
// after the store read and after the multiply, and each row's sum is held
// in the output register. Each result carries its row and last marks the
// final row. Stores must be written before they are read; nothing enforces it.
// Output channel (o_out_valid / i_out_stall): results are held in an output
// register; while the receiver stalls, the MAC pipeline freezes and no word
// is lost. Queued loads wait until the running compute has read all its data.
// Reset (i_rst_n low, synchronous) empties the queue and pipeline and sets
// rows_in_use = 16, cols_in_use = 16, use_bias = 1. Configuration writes
// (index 0 rows, 1 cols, 2 use_bias) must only be made while the core is idle.
// ----------------------------------------------------------------------------
module matrix_vector_affine_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mva_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_func,
    input  logic [mva_pkg::ROW_W-1:0]             i_row,
    input  logic [mva_pkg::COL_W-1:0]             i_col,
    input  logic signed [mva_pkg::DATA_WIDTH-1:0] i_value,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [mva_pkg::ROW_W-1:0]             o_row_index,
    output logic signed [mva_pkg::SUM_W-1:0]      o_sum_value,
    output logic                                  o_last
);
    import mva_pkg::*;

    logic   item_valid;
    t_item  item;
    logic   item_pop;
    t_cfg   cfg;

    mva_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_value      (i_value),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop),
        .o_cfg        (cfg)
    );

    mva_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_cfg        (cfg),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_row_index  (o_row_index),
        .o_sum_value  (o_sum_value),
        .o_last       (o_last)
    );

endmodule

// ===== bench/mva_affine_checker.sv =====
// ----------------------------------------------------------------------------
// mva_affine_checker
// Watches both channels of the matrix-vector affine core, keeps its own copy
// of the matrix, vector and bias stores and the shape registers, predicts the
// result rows of every accepted compute word and compares each accepted
// result word field by field against the oldest predicted row.
// ----------------------------------------------------------------------------
module mva_affine_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [mva_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mva_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_stall,
    input  logic [1:0]                            i_func,
    input  logic [mva_pkg::ROW_W-1:0]             i_row,
    input  logic [mva_pkg::COL_W-1:0]             i_col,
    input  logic signed [mva_pkg::DATA_WIDTH-1:0] i_value,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_stall,
    input  logic [mva_pkg::ROW_W-1:0]             i_row_index,
    input  logic signed [mva_pkg::SUM_W-1:0]      i_sum_value,
    input  logic                                  i_last,
    output int                                    o_fail_count,
    output int                                    o_pending
);
    import mva_pkg::*;

    typedef struct {
        logic [ROW_W-1:0]        row;
        logic signed [SUM_W-1:0] sum;
        logic                    last;
    } t_row_result;

    logic signed [DATA_WIDTH-1:0] mat_copy [MAX_ROWS][MAX_COLS];
    logic signed [DATA_WIDTH-1:0] vec_copy [MAX_COLS];
    logic signed [DATA_WIDTH-1:0] bias_copy [MAX_ROWS];
    logic [CNT_W-1:0]             rows_cfg;
    logic [CNT_W-1:0]             cols_cfg;
    logic                         bias_on;
    t_row_result                  pending_rows [$];
    int                           mismatches = 0;

    assign o_fail_count = mismatches;

    task automatic report_mismatch(input string field, input longint got, input longint want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, field, got, want);
        mismatches++;
    endtask

    function automatic int span_of(input logic [CNT_W-1:0] v, input int ceiling);
        if (v == '0) return 1;
        if (int'(v) > ceiling) return ceiling;
        return int'(v);
    endfunction

    function automatic logic signed [SUM_W-1:0] affine_row(input int r, input int n_cols);
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        acc = '0;
        for (int c = 0; c < n_cols; c++) begin
            acc = acc + mat_copy[r][c] * vec_copy[c];
        end
        if (bias_on) begin
            acc = acc + bias_copy[r] * 64'sd4096;
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > 64'sd2147483647) return 32'sh7fffffff;
        if (scaled < -64'sd2147483648) return 32'sh80000000;
        return SUM_W'(scaled);
    endfunction

    always @(posedge i_clk) begin
        t_row_result want;
        int          n_rows;
        int          n_cols;
        if (!i_rst_n) begin
            rows_cfg = CNT_W'(MAX_ROWS);
            cols_cfg = CNT_W'(MAX_COLS);
            bias_on  = 1'b1;
            pending_rows.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_rows.size() == 0) begin
                    report_mismatch("unexpected result word", i_sum_value, 0);
                end else begin
                    want = pending_rows.pop_front();
                    if (i_row_index !== want.row) begin
                        report_mismatch("row_index", i_row_index, want.row);
                    end
                    if (i_sum_value !== want.sum) begin
                        report_mismatch("sum_value", i_sum_value, want.sum);
                    end
                    if (i_last !== want.last) begin
                        report_mismatch("last", i_last, want.last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ROWS: rows_cfg = i_cfg_data;
                    CFG_COLS: cols_cfg = i_cfg_data;
                    CFG_BIAS: bias_on = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                case (t_op'(i_func))
                    OP_MAT:  mat_copy[i_row][i_col] = i_value;
                    OP_VEC:  vec_copy[i_col] = i_value;
                    OP_BIAS: bias_copy[i_row] = i_value;
                    OP_CALC: begin
                        n_rows = span_of(rows_cfg, MAX_ROWS);
                        n_cols = span_of(cols_cfg, MAX_COLS);
                        for (int r = 0; r < n_rows; r++) begin
                            want.row  = ROW_W'(r);
                            want.sum  = affine_row(r, n_cols);
                            want.last = (r == n_rows - 1);
                            pending_rows.push_back(want);
                        end
                    end
                    default: ;
                endcase
            end
        end
        o_pending <= pending_rows.size();
    end

endmodule

// ===== bench/matrix_vector_affine_core_test.sv =====
// ----------------------------------------------------------------------------
// matrix_vector_affine_core_test
// Regression for the matrix-vector affine core. Preloads row 0 in full, the
// first columns of the other rows, the whole vector and the bias store, runs a
// short directed sequence over value extremes, floor rounding and out-of-range
// shapes, then random phases of loads and computes under shapes that stay
// inside the written area, with bursty input traffic and a patterned output
// stall. Checking is done by mva_affine_checker; this module makes stimulus
// and gives the verdict.
// ----------------------------------------------------------------------------
module matrix_vector_affine_core_test;
    import mva_pkg::*;

    localparam int                           RANDOM_WORDS   = 36;
    localparam int                           PRE_COLS       = 2;
    localparam int                           SETTLE_CYCLES  = 24;
    localparam int                           WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_IDX_W-1:0]         CFG_SPARE      = 2'd3;
    localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN      = 16'sh8000;
    localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX      = 16'sh7fff;

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [1:0]                    func;
    logic [ROW_W-1:0]              in_row;
    logic [COL_W-1:0]              in_col;
    logic signed [DATA_WIDTH-1:0]  in_value;
    logic                          out_valid;
    logic                          out_stall;
    logic [ROW_W-1:0]              row_index;
    logic signed [SUM_W-1:0]       sum_value;
    logic                          last;
    int                            fail_count;
    int                            pending;
    int                            burst_left = 0;
    logic                          steady = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    matrix_vector_affine_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_func      (func),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_row_index (row_index),
        .o_sum_value (sum_value),
        .o_last      (last)
    );

    mva_affine_checker u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_func       (func),
        .i_row        (in_row),
        .i_col        (in_col),
        .i_value      (in_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_row_index  (row_index),
        .i_sum_value  (sum_value),
        .i_last       (last),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return VALUE_MIN;
            1: return VALUE_MAX;
            2: return '0;
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return CFG_DATA_W'(MAX_ROWS);
            2: return CFG_DATA_W'($urandom_range(17, 31));
            3: return CFG_DATA_W'($urandom_range(5, 15));
            default: return CFG_DATA_W'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic put_word(input t_op op, input logic [ROW_W-1:0] row,
                            input logic [COL_W-1:0] col,
                            input logic signed [DATA_WIDTH-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = steady ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        func     <= op;
        in_row   <= row;
        in_col   <= col;
        in_value <= value;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_shape(input logic [CFG_DATA_W-1:0] rows,
                             input logic [CFG_DATA_W-1:0] cols, input logic bias);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_BIAS, CFG_DATA_W'(bias));
    endtask

    task automatic pick_shape();
        if ($urandom_range(0, 1) == 0) begin
            set_shape(pick_count(), CFG_DATA_W'($urandom_range(0, PRE_COLS)),
                      1'($urandom_range(0, 1)));
        end else begin
            set_shape(CFG_DATA_W'($urandom_range(0, 1)), pick_count(),
                      1'($urandom_range(0, 1)));
        end
    endtask

    task automatic put_compute();
        put_word(OP_CALC, ROW_W'($urandom), COL_W'($urandom), DATA_WIDTH'($urandom));
    endtask

    initial begin : receiver_pattern
        int mode;
        int span;
        out_stall = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = (mode == 1) ? $urandom_range(1, 20) : $urandom_range(4, 40);
            repeat (span) begin
                @(negedge clk);
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= 1'b1;
                    default: out_stall <= ($urandom_range(0, 2) == 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("matrix_vector_affine_core regression: fail");
        $finish;
    end

    initial begin : stimulus
        int words_sent;
        t_op op;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        func      = OP_MAT;
        in_row    = '0;
        in_col    = '0;
        in_value  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // row 0 and the whole vector sit at the negative extreme
        for (int c = 0; c < MAX_COLS; c++) begin
            put_word(OP_MAT, ROW_W'(0), COL_W'(c), VALUE_MIN);
        end
        for (int r = 1; r < MAX_ROWS; r++) begin
            for (int c = 0; c < PRE_COLS; c++) begin
                put_word(OP_MAT, ROW_W'(r), COL_W'(c), (r == 1) ? VALUE_MAX : pick_value());
            end
        end
        for (int c = 0; c < MAX_COLS; c++) begin
            put_word(OP_VEC, ROW_W'($urandom), COL_W'(c), VALUE_MIN);
        end
        for (int r = 0; r < MAX_ROWS; r++) begin
            put_word(OP_BIAS, ROW_W'(r), COL_W'($urandom), pick_value());
        end
        settle();

        set_shape(CFG_DATA_W'(0), CFG_DATA_W'(17), 1'b1);
        put_compute();
        settle();

        set_shape(CFG_DATA_W'(1), CFG_DATA_W'(1), 1'b1);
        write_reg(CFG_SPARE, CFG_DATA_W'(7));
        put_word(OP_MAT, ROW_W'(0), COL_W'(0), VALUE_MAX);
        put_word(OP_VEC, ROW_W'($urandom), COL_W'(0), VALUE_MIN);
        put_word(OP_BIAS, ROW_W'(0), COL_W'($urandom), VALUE_MAX);
        put_compute();
        put_word(OP_MAT, ROW_W'(0), COL_W'(0), DATA_WIDTH'(1));
        put_word(OP_VEC, ROW_W'($urandom), COL_W'(0), DATA_WIDTH'(-1));
        put_word(OP_BIAS, ROW_W'(0), COL_W'($urandom), DATA_WIDTH'(0));
        put_compute();
        put_word(OP_BIAS, ROW_W'(0), COL_W'($urandom), VALUE_MIN);
        put_compute();
        settle();

        set_shape(CFG_DATA_W'(0), CFG_DATA_W'(0), 1'b0);
        put_compute();
        put_compute();
        settle();

        set_shape(CFG_DATA_W'(31), CFG_DATA_W'(PRE_COLS), 1'b1);
        put_word(OP_MAT, ROW_W'(MAX_ROWS - 1), COL_W'(PRE_COLS - 1), VALUE_MIN);
        put_word(OP_VEC, ROW_W'($urandom), COL_W'(PRE_COLS - 1), VALUE_MAX);
        put_word(OP_BIAS, ROW_W'(MAX_ROWS - 1), COL_W'($urandom), VALUE_MIN);
        put_compute();
        settle();

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            pick_shape();
            steady = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(4, 12)) begin
                if ($urandom_range(0, 3) == 0) begin
                    put_compute();
                end else begin
                    op = t_op'($urandom_range(0, 2));
                    put_word(op, ROW_W'($urandom), COL_W'($urandom), pick_value());
                end
                words_sent++;
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("matrix_vector_affine_core regression: pass");
        end else begin
            $display("matrix_vector_affine_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mva_pkg.sv
rtl/mva_front.sv
rtl/mva_back.sv
rtl/matrix_vector_affine_core.sv
bench/mva_affine_checker.sv
bench/matrix_vector_affine_core_test.sv
